// ===== hw/rtl/bb3_pkg.sv =====
// Shared types, constants and helper functions for the 3x3 RGB box blur.
package bb3_pkg;

   localparam int DEFAULT_MAX_WIDTH = 1024;
   localparam int DEFAULT_MAX_HEIGHT = 4096;
   localparam int RESET_DIM = 1024;
   localparam int TAP_COUNT = 9;
   localparam int TAP_LAST = TAP_COUNT - 1;

   localparam logic CSR_WIDTH = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   localparam logic signed [1:0] TAP_ROW_OFS [0:8] = '{
      -2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd1, 2'sd1, 2'sd1};
   localparam logic signed [1:0] TAP_COL_OFS [0:8] = '{
      -2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd1};

   typedef struct packed {
      logic       accept;
      logic       clear;
      logic       tap_read;
      logic       div_a;
      logic       div_b;
      logic       load;
      logic       last;
      logic [1:0] k;
      logic [3:0] tap;
   } cmd_type;

   typedef struct packed {
      logic [3:0] due;
      logic       out_free;
   } status_type;

   // Floor of 65536 / (2 * count) for a neighborhood count of 1 to 9.
   function automatic logic [15:0] recip(input logic [3:0] cnt);
      logic [15:0] r;
      case (cnt)
         4'd2:    r = 16'd16384;
         4'd3:    r = 16'd10922;
         4'd4:    r = 16'd8192;
         4'd5:    r = 16'd6553;
         4'd6:    r = 16'd5461;
         4'd7:    r = 16'd4681;
         4'd8:    r = 16'd4096;
         4'd9:    r = 16'd3640;
         default: r = 16'd32768;
      endcase
      return r;
   endfunction

   // Line slot of a row that lies ofs rows away from the row held in slot s.
   function automatic logic [1:0] slot_add(input logic [1:0] s, input logic signed [2:0] ofs);
      int v;
      v = int'(s) + int'(ofs) + 3;
      if (v >= 6) begin
         v = v - 6;
      end else if (v >= 3) begin
         v = v - 3;
      end
      return v[1:0];
   endfunction

endpackage

// ===== hw/rtl/box_blur_3x3_rgb.sv =====
// Top level of the streaming 3x3 box blur over RGB pixels with three line buffers.
//
//  channel | dir | handshake           | payload
//  req     | in  | req_valid/req_stall | req_in_red, req_in_green, req_in_blue
//  rsp     | out | rsp_valid/rsp_stall | rsp_out_red/green/blue, rsp_out_row/col, rsp_run_last
//  csr     | in  | csr_valid/csr_ready | csr_index, csr_data
//
// A request is accepted; each of its n due results (0 to 4) passes a slot check, nine reads of
// the line store, a drain step, two divide steps and output. Slots not due before the last
// result are checked and skipped (all four when n is 0); a full output register adds waits.
// Reset clears the position and sets both dimensions to 1024; the line store is not cleared.
// req_stall is high while a request is being worked; rsp_stall holds the result in place.
module box_blur_3x3_rgb #(
   parameter int MAX_WIDTH = bb3_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = bb3_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_red,
   input  logic [7:0]  req_in_green,
   input  logic [7:0]  req_in_blue,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   output logic [11:0] rsp_out_row,
   output logic [9:0]  rsp_out_col,
   output logic        rsp_run_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [12:0] csr_data
);

   bb3_pkg::cmd_type    cmd;
   bb3_pkg::status_type status;

   assign csr_ready = 1'b1;

   bb3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bb3_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_in_red    (req_in_red),
      .req_in_green  (req_in_green),
      .req_in_blue   (req_in_blue),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_run_last  (rsp_run_last)
   );

endmodule

// ===== hw/rtl/bb3_ctrl.sv =====
// Sequencer that walks the due results of one request through taps, divide and output.
module bb3_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  bb3_pkg::status_type status,
   output bb3_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SELECT, ST_TAPS, ST_DRAIN, ST_DIVA, ST_DIVB, ST_EMIT
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] k_ff, k_in;
   logic [3:0] tap_ff, tap_in;
   logic       last;

   always_comb begin
      case (k_ff)
         2'd0:    last = ~|status.due[3:1];
         2'd1:    last = ~|status.due[3:2];
         2'd2:    last = ~status.due[3];
         default: last = 1'b1;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      k_in = k_ff;
      tap_in = tap_ff;
      cmd = '0;
      cmd.k = k_ff;
      cmd.tap = tap_ff;
      cmd.last = last;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               k_in = 2'd0;
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            if (status.due[k_ff]) begin
               cmd.clear = 1'b1;
               tap_in = 4'd0;
               state_in = ST_TAPS;
            end else if (k_ff == 2'd3) begin
               state_in = ST_IDLE;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         ST_TAPS: begin
            cmd.tap_read = 1'b1;
            if (tap_ff == 4'(bb3_pkg::TAP_LAST)) begin
               state_in = ST_DRAIN;
            end else begin
               tap_in = tap_ff + 4'd1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DIVA;
         end
         ST_DIVA: begin
            cmd.div_a = 1'b1;
            state_in = ST_DIVB;
         end
         ST_DIVB: begin
            cmd.div_b = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               if (last) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in = k_ff + 2'd1;
                  state_in = ST_SELECT;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff <= 2'd0;
         tap_ff <= 4'd0;
      end else begin
         state_ff <= state_in;
         k_ff <= k_in;
         tap_ff <= tap_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      tap_ff <= 4'(bb3_pkg::TAP_LAST))
      else $error("tap counter out of range");

   a_taps_due: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TAPS |-> status.due[k_ff])
      else $error("reading taps for a result that is not due");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> status.out_free)
      else $error("output register overwritten");

endmodule

// ===== hw/rtl/bb3_dp.sv =====
// Datapath: dimension registers, position counters, line store, accumulators, divider, output.
module bb3_dp #(
   parameter int MAX_WIDTH = bb3_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = bb3_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                clock,
   input  logic                reset,
   input  bb3_pkg::cmd_type    cmd,
   output bb3_pkg::status_type status,
   input  logic [7:0]          req_in_red,
   input  logic [7:0]          req_in_green,
   input  logic [7:0]          req_in_blue,
   input  logic                csr_valid,
   input  logic                csr_index,
   input  logic [12:0]         csr_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_red,
   output logic [7:0]          rsp_out_green,
   output logic [7:0]          rsp_out_blue,
   output logic [11:0]         rsp_out_row,
   output logic [9:0]          rsp_out_col,
   output logic                rsp_run_last
);

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int DEPTH = 3 * MAX_WIDTH;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WW-1:0] width_ff, row_w;
   logic [HW-1:0] height_ff, row_h;
   logic [HW-1:0] row_ff, item_row_ff;
   logic [WW-1:0] col_ff, item_col_ff;
   logic [1:0]    slot_ff, item_slot_ff;
   logic [3:0]    due_ff, due_in;

   logic [23:0]   mem [DEPTH];
   logic [23:0]   rd_data_ff;
   logic          rd_ok_ff, rd_ok_in;
   logic [AW-1:0] wr_addr, rd_addr;

   logic [2:0][11:0] sum_ff;
   logic [3:0]       cnt_ff, cnt_eff;
   logic [2:0][12:0] num_ff;
   logic [2:0][28:0] prod_ff;
   logic [4:0]       den_ff;
   logic [2:0][7:0]  q_ff;
   logic             out_valid_ff;

   logic [31:0] wclamp, hclamp;
   logic signed [2:0] ro, co;
   logic signed [HW+1:0] rr;
   logic signed [WW+1:0] cc;
   logic [1:0] rd_slot;
   logic [31:0] pr32, pc32;

   always_comb begin
      if (csr_data[10:0] == 11'd0) begin
         wclamp = 32'd1;
      end else if (32'(csr_data[10:0]) > 32'(MAX_WIDTH)) begin
         wclamp = 32'(MAX_WIDTH);
      end else begin
         wclamp = 32'(csr_data[10:0]);
      end
      if (csr_data == 13'd0) begin
         hclamp = 32'd1;
      end else if (32'(csr_data) > 32'(MAX_HEIGHT)) begin
         hclamp = 32'(MAX_HEIGHT);
      end else begin
         hclamp = 32'(csr_data);
      end
   end

   assign row_w = width_ff - WW'(1);
   assign row_h = height_ff - HW'(1);

   always_comb begin
      due_in[0] = (row_ff != '0) && (col_ff != '0);
      due_in[1] = (row_ff != '0) && (col_ff == row_w);
      due_in[2] = (row_ff == row_h) && (col_ff != '0);
      due_in[3] = (row_ff == row_h) && (col_ff == row_w);
   end

   always_comb begin
      ro = (cmd.k[1] ? 3'sd0 : -3'sd1) + 3'(bb3_pkg::TAP_ROW_OFS[cmd.tap]);
      co = (cmd.k[0] ? 3'sd0 : -3'sd1) + 3'(bb3_pkg::TAP_COL_OFS[cmd.tap]);
      rr = $signed({2'b00, item_row_ff}) + (HW+2)'(ro);
      cc = $signed({2'b00, item_col_ff}) + (WW+2)'(co);
      rd_slot = bb3_pkg::slot_add(item_slot_ff, ro);
      rd_ok_in = cmd.tap_read && (rr >= 0) && (rr < $signed({2'b00, height_ff}))
         && (cc >= 0) && (cc < $signed({2'b00, width_ff}));
      rd_addr = AW'(32'(rd_slot) * 32'(MAX_WIDTH) + 32'(cc[WW-1:0]));
      wr_addr = AW'(32'(slot_ff) * 32'(MAX_WIDTH) + 32'(col_ff));
      cnt_eff = (cnt_ff == 4'd0) ? 4'd1 : cnt_ff;
      pr32 = 32'(item_row_ff) - 32'(!cmd.k[1]);
      pc32 = 32'(item_col_ff) - 32'(!cmd.k[0]);
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mem[wr_addr] <= {req_in_red, req_in_green, req_in_blue};
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WW'(bb3_pkg::RESET_DIM < MAX_WIDTH ? bb3_pkg::RESET_DIM : MAX_WIDTH);
         height_ff <= HW'(bb3_pkg::RESET_DIM < MAX_HEIGHT ? bb3_pkg::RESET_DIM : MAX_HEIGHT);
         row_ff <= '0;
         col_ff <= '0;
         slot_ff <= 2'd0;
         due_ff <= 4'd0;
         rd_ok_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rd_ok_ff <= rd_ok_in;
         if (csr_valid) begin
            if (csr_index == bb3_pkg::CSR_WIDTH) begin
               width_ff <= wclamp[WW-1:0];
            end else begin
               height_ff <= hclamp[HW-1:0];
            end
            row_ff <= '0;
            col_ff <= '0;
            slot_ff <= 2'd0;
         end else if (cmd.accept) begin
            due_ff <= due_in;
            if (col_ff == row_w) begin
               col_ff <= '0;
               if (row_ff == row_h) begin
                  row_ff <= '0;
                  slot_ff <= 2'd0;
               end else begin
                  row_ff <= row_ff + HW'(1);
                  slot_ff <= (slot_ff == 2'd2) ? 2'd0 : slot_ff + 2'd1;
               end
            end else begin
               col_ff <= col_ff + WW'(1);
            end
         end
         if (cmd.load) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_row_ff <= row_ff;
         item_col_ff <= col_ff;
         item_slot_ff <= slot_ff;
      end
      if (cmd.clear) begin
         sum_ff <= '0;
         cnt_ff <= 4'd0;
      end else if (rd_ok_ff) begin
         sum_ff[0] <= sum_ff[0] + 12'(rd_data_ff[23:16]);
         sum_ff[1] <= sum_ff[1] + 12'(rd_data_ff[15:8]);
         sum_ff[2] <= sum_ff[2] + 12'(rd_data_ff[7:0]);
         cnt_ff <= cnt_ff + 4'd1;
      end
      if (cmd.div_a) begin
         for (int i = 0; i < 3; i++) begin
            num_ff[i] <= {sum_ff[i], 1'b0} + 13'(cnt_eff);
            prod_ff[i] <= 29'({sum_ff[i], 1'b0} + 13'(cnt_eff)) * 29'(bb3_pkg::recip(cnt_eff));
         end
         den_ff <= {cnt_eff, 1'b0};
      end
      if (cmd.div_b) begin
         for (int i = 0; i < 3; i++) begin
            if (18'(num_ff[i]) - 18'(prod_ff[i][28:16]) * 18'(den_ff) >= 18'(den_ff)) begin
               q_ff[i] <= 8'(prod_ff[i][28:16] + 13'd1);
            end else begin
               q_ff[i] <= prod_ff[i][23:16];
            end
         end
      end
      if (cmd.load) begin
         rsp_out_red <= q_ff[0];
         rsp_out_green <= q_ff[1];
         rsp_out_blue <= q_ff[2];
         rsp_out_row <= pr32[11:0];
         rsp_out_col <= pc32[9:0];
         rsp_run_last <= cmd.last;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign status.due = due_ff;
   assign status.out_free = !out_valid_ff;

endmodule
